@@ rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// No dependencies; the interfaces, the top level and the bench import this package.

package deq_pkg;

   // Widths of the transaction fields
   localparam int CMD_WIDTH         = 3;
   localparam int FIELD_WIDTH       = 32;
   localparam int COUNT_FIELD_WIDTH = 11;

   // Command codes carried by a request transaction
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_STATUS     = 3'd4
   } cmd_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_FILL
   } state_type;

endpackage

@@ rtl/deq_req_if.sv @@
`timescale 1ns / 1ps
// Request channel of the double-ended queue: valid/ready plus command and data word.
// Depends on deq_pkg for the field widths.

interface deq_req_if;
   import deq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [CMD_WIDTH-1:0]          command;
   logic signed [FIELD_WIDTH-1:0] push_value;

   modport source (output valid, output command, output push_value, input ready);
   modport sink   (input valid, input command, input push_value, output ready);
endinterface

@@ rtl/deq_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel of the double-ended queue: valid/ready plus the result fields.
// Depends on deq_pkg for the field widths.

interface deq_rsp_if;
   import deq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] pop_value;
   logic                          pop_valid;
   logic                          underflow;
   logic                          overflow;
   logic [COUNT_FIELD_WIDTH-1:0]  entry_count;
   logic                          is_empty;
   logic signed [FIELD_WIDTH-1:0] front_value;
   logic signed [FIELD_WIDTH-1:0] back_value;

   modport source (output valid, output pop_value, output pop_valid, output underflow,
                   output overflow, output entry_count, output is_empty,
                   output front_value, output back_value, input ready);
   modport sink   (input valid, input pop_value, input pop_valid, input underflow,
                   input overflow, input entry_count, input is_empty,
                   input front_value, input back_value, output ready);
endinterface

@@ rtl/deq_store.sv @@
`timescale 1ns / 1ps
// Word store of the double-ended queue: one write port, one read port,
// read data registered. No package dependencies.

module deq_store #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write the entry on a push
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/double_ended_queue.sv @@
`timescale 1ns / 1ps
// Double-ended queue top level: controller, pointers, cached end words, response register.
// Depends on deq_pkg, deq_req_if, deq_rsp_if and deq_store.

// A double-ended queue of DEPTH words held in a single-port-read synchronous store.
// Every request transaction (push front/back, pop front/back, status) returns exactly
// one response transaction with the popped word, underflow/overflow flags, the entry
// count and the words now at both ends (0 when empty). The words at both ends are kept
// in registers, so pushes, status requests, failed pops and pops that leave fewer than
// two words are answered without a store read. A pop that leaves two or more words also
// passes through the fill state, since the new end word must be read back through the
// store's registered read port. A request is taken when the controller is idle and the
// response register is empty or being drained in the same cycle. The store needs no clearing after reset.

module double_ended_queue #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);
   import deq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Pointer arithmetic with wrap at DEPTH
   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
   endfunction

   // Stored word to 32-bit result field
   function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [DATA_WIDTH-1:0] w);
      logic [63:0] wide;
      wide = 64'(w);
      return wide[FIELD_WIDTH-1:0];
   endfunction

   // Control state
   state_type     state_ff, state_in;
   logic [AW-1:0] front_ptr_ff, front_ptr_in;
   logic [AW-1:0] back_ptr_ff, back_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [DATA_WIDTH-1:0]        front_word_ff, front_word_in;
   logic [DATA_WIDTH-1:0]        back_word_ff, back_word_in;
   logic                         fill_front_ff, fill_front_in;
   logic [FIELD_WIDTH-1:0]       pop_value_ff, pop_value_in;
   logic                         pop_valid_ff, pop_valid_in;
   logic                         underflow_ff, underflow_in;
   logic                         overflow_ff, overflow_in;
   logic [COUNT_FIELD_WIDTH-1:0] entry_count_ff, entry_count_in;
   logic                         is_empty_ff, is_empty_in;
   logic [FIELD_WIDTH-1:0]       front_value_ff, front_value_in;
   logic [FIELD_WIDTH-1:0]       back_value_ff, back_value_in;

   // Store ports
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   logic                  req_ready;
   logic                  accept;
   logic [63:0]           push_wide;
   logic [DATA_WIDTH-1:0] push_word;
   logic [63:0]           count_wide;
   logic                  q_full;
   logic                  q_empty;
   logic                  q_many;
   logic                  q_two;
   logic [DATA_WIDTH-1:0] popped;

   deq_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_deq_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Take a request only when idle and the response slot frees up
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept    = req_chan.valid && req_ready;

   // Fit the pushed word to the store width
   assign push_wide = {32'd0, req_chan.push_value};
   assign push_word = push_wide[DATA_WIDTH-1:0];

   assign q_full  = (count_ff == CW'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_two   = (count_ff == CW'(2));
   assign q_many  = (count_ff > CW'(2));

   assign count_wide = 64'(count_in);

   // Next state, store accesses and response contents
   always_comb begin
      state_in       = state_ff;
      front_ptr_in   = front_ptr_ff;
      back_ptr_in    = back_ptr_ff;
      count_in       = count_ff;
      front_word_in  = front_word_ff;
      back_word_in   = back_word_ff;
      fill_front_in  = fill_front_ff;
      pop_value_in   = pop_value_ff;
      pop_valid_in   = pop_valid_ff;
      underflow_in   = underflow_ff;
      overflow_in    = overflow_ff;
      entry_count_in = entry_count_ff;
      is_empty_in    = is_empty_ff;
      front_value_in = front_value_ff;
      back_value_in  = back_value_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      wr_en          = 1'b0;
      wr_addr        = back_ptr_ff;
      wr_data        = push_word;
      rd_en          = 1'b0;
      rd_addr        = ptr_inc(front_ptr_ff);
      popped         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pop_valid_in = 1'b0;
               underflow_in = 1'b0;
               overflow_in  = 1'b0;
               case (cmd_type'(req_chan.command))
                  CMD_PUSH_FRONT: begin
                     if (q_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = ptr_dec(front_ptr_ff);
                        front_ptr_in  = ptr_dec(front_ptr_ff);
                        count_in      = count_ff + 1'b1;
                        front_word_in = push_word;
                        if (q_empty) begin
                           back_word_in = push_word;
                        end
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (q_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = back_ptr_ff;
                        back_ptr_in  = ptr_inc(back_ptr_ff);
                        count_in     = count_ff + 1'b1;
                        back_word_in = push_word;
                        if (q_empty) begin
                           front_word_in = push_word;
                        end
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (q_empty) begin
                        underflow_in = 1'b1;
                     end else begin
                        popped       = front_word_ff;
                        pop_valid_in = 1'b1;
                        front_ptr_in = ptr_inc(front_ptr_ff);
                        count_in     = count_ff - 1'b1;
                        if (q_two) begin
                           front_word_in = back_word_ff;
                        end
                        // Refetch the new front word from the store
                        if (q_many) begin
                           rd_en         = 1'b1;
                           rd_addr       = ptr_inc(front_ptr_ff);
                           fill_front_in = 1'b1;
                           state_in      = ST_FILL;
                        end
                     end
                  end
                  CMD_POP_BACK: begin
                     if (q_empty) begin
                        underflow_in = 1'b1;
                     end else begin
                        popped       = back_word_ff;
                        pop_valid_in = 1'b1;
                        back_ptr_in  = ptr_dec(back_ptr_ff);
                        count_in     = count_ff - 1'b1;
                        if (q_two) begin
                           back_word_in = front_word_ff;
                        end
                        // Refetch the new back word from the store
                        if (q_many) begin
                           rd_en         = 1'b1;
                           rd_addr       = ptr_dec(ptr_dec(back_ptr_ff));
                           fill_front_in = 1'b0;
                           state_in      = ST_FILL;
                        end
                     end
                  end
                  CMD_STATUS: begin
                     // report only
                  end
                  default: begin
                     // unused codes report like status
                  end
               endcase

               pop_value_in   = to_field(popped);
               entry_count_in = count_wide[COUNT_FIELD_WIDTH-1:0];
               is_empty_in    = (count_in == '0);
               front_value_in = (count_in == '0) ? '0 : to_field(front_word_in);
               back_value_in  = (count_in == '0) ? '0 : to_field(back_word_in);
               // Present now unless an end word is still being fetched
               rsp_valid_in   = !rd_en;
            end
         end
         ST_FILL: begin
            // Land the fetched end word and release the response
            if (fill_front_ff) begin
               front_word_in  = rd_data;
               front_value_in = to_field(rd_data);
            end else begin
               back_word_in  = rd_data;
               back_value_in = to_field(rd_data);
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ptr_ff <= '0;
         back_ptr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ptr_ff <= front_ptr_in;
         back_ptr_ff  <= back_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      front_word_ff  <= front_word_in;
      back_word_ff   <= back_word_in;
      fill_front_ff  <= fill_front_in;
      pop_value_ff   <= pop_value_in;
      pop_valid_ff   <= pop_valid_in;
      underflow_ff   <= underflow_in;
      overflow_ff    <= overflow_in;
      entry_count_ff <= entry_count_in;
      is_empty_ff    <= is_empty_in;
      front_value_ff <= front_value_in;
      back_value_ff  <= back_value_in;
   end

   // Drive the channels
   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pop_value   = $signed(pop_value_ff);
   assign rsp_chan.pop_valid   = pop_valid_ff;
   assign rsp_chan.underflow   = underflow_ff;
   assign rsp_chan.overflow    = overflow_ff;
   assign rsp_chan.entry_count = entry_count_ff;
   assign rsp_chan.is_empty    = is_empty_ff;
   assign rsp_chan.front_value = $signed(front_value_ff);
   assign rsp_chan.back_value  = $signed(back_value_ff);

endmodule

@@ rtl/deq_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the double-ended queue, bound to the top level.
// Depends on deq_req_if, deq_rsp_if and double_ended_queue.

module deq_checker (
   input logic       clock,
   input logic       reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);

   // Empty flag agrees with the entry count
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.is_empty == (rsp_chan.entry_count == '0)))
      else $error("is_empty disagrees with entry_count");

   // Both end words read zero on an empty queue
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.is_empty) |->
         (rsp_chan.front_value == '0 && rsp_chan.back_value == '0))
      else $error("end words nonzero on empty queue");

   // Outcome flags are exclusive and a failed or absent pop returns zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (!(rsp_chan.pop_valid && rsp_chan.underflow)
          && !(rsp_chan.overflow && (rsp_chan.pop_valid || rsp_chan.underflow))
          && (rsp_chan.pop_valid || rsp_chan.pop_value == '0)))
      else $error("inconsistent outcome flags");

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(rsp_chan.pop_value) && $stable(rsp_chan.entry_count)
          && $stable(rsp_chan.front_value) && $stable(rsp_chan.back_value)))
      else $error("stalled response changed");

   // Take a request only while the response slot is free or draining
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && rsp_chan.valid) |-> rsp_chan.ready)
      else $error("request taken while response slot stays full");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue: directed corner cases, then random traffic.
// Depends on deq_pkg, deq_req_if, deq_rsp_if and the double_ended_queue RTL.

module tb_top;
   import deq_pkg::*;

   localparam int QUEUE_DEPTH = 1024;

   // One response transaction as seen on the result channel
   typedef struct {
      logic signed [FIELD_WIDTH-1:0] pop_value;
      logic                          pop_valid;
      logic                          underflow;
      logic                          overflow;
      logic [COUNT_FIELD_WIDTH-1:0]  entry_count;
      logic                          is_empty;
      logic signed [FIELD_WIDTH-1:0] front_value;
      logic signed [FIELD_WIDTH-1:0] back_value;
   } deq_result_type;

   // Shadow deque plus the in-order list of responses it predicts
   class deque_scoreboard_type;
      logic signed [FIELD_WIDTH-1:0] words[$];
      deq_result_type                expected_results[$];
      int errors, checked, underflows, overflows, max_depth;

      function int pending();
         return expected_results.size();
      endfunction

      // Apply one accepted request to the shadow deque and queue its response
      function void note_request(logic [CMD_WIDTH-1:0] cmd,
                                 logic signed [FIELD_WIDTH-1:0] value);
         deq_result_type r;
         r = '{default: '0};
         case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
               if (words.size() >= QUEUE_DEPTH) begin
                  r.overflow = 1'b1;
                  overflows++;
               end else if (cmd == CMD_PUSH_FRONT) begin
                  words.insert(0, value);
               end else begin
                  words.insert(words.size(), value);
               end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
               if (words.size() == 0) begin
                  r.underflow = 1'b1;
                  underflows++;
               end else begin
                  r.pop_valid = 1'b1;
                  if (cmd == CMD_POP_FRONT) begin
                     r.pop_value = words[0];
                     words.delete(0);
                  end else begin
                     r.pop_value = words[words.size() - 1];
                     words.delete(words.size() - 1);
                  end
               end
            end
            default: ;
         endcase
         r.entry_count = COUNT_FIELD_WIDTH'(words.size());
         r.is_empty    = (words.size() == 0);
         if (words.size() != 0) begin
            r.front_value = words[0];
            r.back_value  = words[$];
         end
         if (words.size() > max_depth) max_depth = words.size();
         expected_results.insert(expected_results.size(), r);
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // Match one response transaction against the oldest prediction
      function void check_response(deq_result_type got);
         deq_result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            errors++;
            return;
         end
         want = expected_results[0];
         expected_results.delete(0);
         compare_field("pop_value", 64'(want.pop_value), 64'(got.pop_value));
         compare_field("pop_valid", 64'(want.pop_valid), 64'(got.pop_valid));
         compare_field("underflow", 64'(want.underflow), 64'(got.underflow));
         compare_field("overflow", 64'(want.overflow), 64'(got.overflow));
         compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
         compare_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
         compare_field("front_value", 64'(want.front_value), 64'(got.front_value));
         compare_field("back_value", 64'(want.back_value), 64'(got.back_value));
         checked++;
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   items_sent;

   deque_scoreboard_type sb = new();

   deq_req_if req_bus();
   deq_rsp_if rsp_bus();

   double_ended_queue #(
      .DEPTH      (QUEUE_DEPTH),
      .DATA_WIDTH (FIELD_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Hard stop if the run hangs
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Throttle the result channel
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Check responses, then record newly accepted requests
   always @(posedge clock) begin
      deq_result_type seen;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.pop_value   = rsp_bus.pop_value;
            seen.pop_valid   = rsp_bus.pop_valid;
            seen.underflow   = rsp_bus.underflow;
            seen.overflow    = rsp_bus.overflow;
            seen.entry_count = rsp_bus.entry_count;
            seen.is_empty    = rsp_bus.is_empty;
            seen.front_value = rsp_bus.front_value;
            seen.back_value  = rsp_bus.back_value;
            sb.check_response(seen);
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.command, req_bus.push_value);
         end
      end
   end

   // Present one request and hold it until the block takes it
   task automatic send_request(input logic [CMD_WIDTH-1:0] cmd,
                               input logic signed [FIELD_WIDTH-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.push_value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // Mostly full-range words, with the sign and zero corners mixed in
   function automatic logic signed [FIELD_WIDTH-1:0] pick_word();
      case ($urandom_range(15))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Random commands with a chosen push/pop mix; the rest are status or unknown codes
   task automatic run_random(input int count, input int push_pct, input int pop_pct);
      logic [CMD_WIDTH-1:0] cmd;
      int                   roll;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < push_pct)
            cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         else if (roll < push_pct + pop_pct)
            cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
         else
            cmd = CMD_STATUS | CMD_WIDTH'($urandom_range(3));
         send_request(cmd, pick_word());
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.command    <= CMD_STATUS;
      req_bus.push_value <= '0;
      recv_stall_pct     <= 0;
      send_idle_pct       = 0;
      items_sent          = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty queue, unknown codes, sign extremes, wrap below zero
      send_request(CMD_STATUS, 32'sh1234_5678);
      send_request(CMD_POP_FRONT, 32'sh7FFF_FFFF);
      send_request(CMD_POP_BACK, '1);
      send_request(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_request(CMD_PUSH_BACK, 32'sh8000_0000);
      send_request(CMD_PUSH_FRONT, '0);
      send_request(CMD_PUSH_BACK, '1);
      send_request(CMD_STATUS, '1);
      send_request(CMD_STATUS | CMD_WIDTH'(1), 32'sh5555_5555);
      send_request(CMD_STATUS | CMD_WIDTH'(2), 32'shAAAA_AAAA);
      send_request(CMD_STATUS | CMD_WIDTH'(3), '1);
      send_request(CMD_POP_FRONT, '0);
      send_request(CMD_POP_BACK, '0);
      send_request(CMD_POP_BACK, '0);
      send_request(CMD_POP_FRONT, '0);
      send_request(CMD_POP_BACK, '0);
      send_request(CMD_PUSH_BACK, 32'sh5555_5555);
      send_request(CMD_PUSH_FRONT, 32'shAAAA_AAAA);
      send_request(CMD_POP_FRONT, '0);
      send_request(CMD_POP_FRONT, '0);
      send_request(CMD_PUSH_FRONT, 32'sh0000_0001);
      send_request(CMD_POP_BACK, '0);

      // Balanced traffic near empty, no idling
      run_random(80, 40, 45);

      // Fill past full with a slow sender
      send_idle_pct = 53;
      run_random(1150, 95, 3);

      // Sit at full with a stalling receiver
      send_idle_pct   = 0;
      recv_stall_pct <= 53;
      run_random(60, 60, 35);

      // Light idling on both sides
      send_idle_pct   = 13;
      recv_stall_pct <= 13;
      run_random(60, 45, 45);

      // Drain outstanding responses, then let the pipeline settle
      req_bus.valid  <= 1'b0;
      recv_stall_pct <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses", items_sent, sb.checked);
      $display("Saw %0d underflows and %0d overflows, peak depth %0d of %0d",
               sb.underflows, sb.overflows, sb.max_depth, QUEUE_DEPTH);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/deq_pkg.sv
rtl/deq_req_if.sv
rtl/deq_rsp_if.sv
rtl/deq_store.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
bench/tb_top.sv
